[rtl/hpdt_pkg.sv]
// shared types, codes and decode functions for the hall position tracker
`timescale 1ns / 1ps
`default_nettype none
package hpdt_pkg;

  // position codes
  localparam logic [2:0] POS_UNKNOWN    = 3'd0;
  localparam logic [2:0] POS_TRANSITION = 3'd1;
  localparam logic [2:0] POS_HOME       = 3'd2;
  localparam logic [2:0] POS_DUMP       = 3'd3;
  localparam logic [2:0] POS_RETURN     = 3'd4;
  localparam logic [2:0] POS_INVALID    = 3'd5;

  // reached event codes
  localparam logic [1:0] EVT_NULL   = 2'd0;
  localparam logic [1:0] EVT_HOME   = 2'd1;
  localparam logic [1:0] EVT_DUMP   = 2'd2;
  localparam logic [1:0] EVT_RETURN = 2'd3;

  // cleaning phase codes
  localparam logic [1:0] PH_NONE   = 2'd0;
  localparam logic [1:0] PH_DUMP   = 2'd1;
  localparam logic [1:0] PH_RETURN = 2'd2;
  localparam logic [1:0] PH_HOME   = 2'd3;

  // sensor patterns: no bit or a single one-hot bit set
  localparam logic [2:0] HALL_NONE   = 3'b000;
  localparam logic [2:0] HALL_HOME   = 3'b001;
  localparam logic [2:0] HALL_DUMP   = 3'b010;
  localparam logic [2:0] HALL_RETURN = 3'b100;

  // register indexes
  localparam logic [1:0] CFG_PIN_POLARITY  = 2'd0;
  localparam logic [1:0] CFG_SAMPLE_PERIOD = 2'd1;
  localparam logic [1:0] CFG_SETTLE_PERIOD = 2'd2;

  // register reset values
  localparam logic        RST_PIN_POLARITY  = 1'b0;
  localparam logic [15:0] RST_SAMPLE_PERIOD = 16'd10;
  localparam logic [15:0] RST_SETTLE_PERIOD = 16'd20;

  typedef struct packed {
    logic        pin_polarity;
    logic [15:0] sample_period;
    logic [15:0] settle_period;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_tick;
    logic [2:0]  hall_levels;
    logic        is_cleaning;
    logic [1:0]  clean_phase;
    logic        waste_full;
    logic        protect;
  } item_t;

  typedef struct packed {
    logic [2:0] held_position;
    logic       stable_changed;
    logic [1:0] reached_event;
  } result_t;

  function automatic logic [2:0] decode_bits(input logic [2:0] bits);
    logic [2:0] pos;
    case (bits)
      HALL_NONE:   pos = POS_TRANSITION;
      HALL_HOME:   pos = POS_HOME;
      HALL_DUMP:   pos = POS_DUMP;
      HALL_RETURN: pos = POS_RETURN;
      default:     pos = POS_INVALID;
    endcase
    return pos;
  endfunction

  function automatic logic [2:0] phase_target(input logic [1:0] phase);
    logic [2:0] pos;
    case (phase)
      PH_DUMP:   pos = POS_DUMP;
      PH_RETURN: pos = POS_RETURN;
      PH_HOME:   pos = POS_HOME;
      default:   pos = POS_UNKNOWN;
    endcase
    return pos;
  endfunction

  function automatic logic [1:0] event_of(input logic [2:0] pos);
    logic [1:0] evt;
    case (pos)
      POS_HOME:   evt = EVT_HOME;
      POS_DUMP:   evt = EVT_DUMP;
      POS_RETURN: evt = EVT_RETURN;
      default:    evt = EVT_NULL;
    endcase
    return evt;
  endfunction

  // signed reading of a 32-bit tick difference below a 16-bit bound
  function automatic logic elapsed_below(input logic [31:0] diff, input logic [15:0] bound);
    return diff[31] || (diff < {16'd0, bound});
  endfunction

endpackage
`default_nettype wire

[rtl/hpdt_config.sv]
// configuration register file for the hall position tracker
`timescale 1ns / 1ps
`default_nettype none
module hpdt_config (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [15:0]      cfg_data,
  output hpdt_pkg::cfg_t        cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pin_polarity  <= hpdt_pkg::RST_PIN_POLARITY;
      cfg.sample_period <= hpdt_pkg::RST_SAMPLE_PERIOD;
      cfg.settle_period <= hpdt_pkg::RST_SETTLE_PERIOD;
    end else if (cfg_valid) begin
      case (cfg_index)
        hpdt_pkg::CFG_PIN_POLARITY:  cfg.pin_polarity  <= cfg_data[0];
        hpdt_pkg::CFG_SAMPLE_PERIOD: cfg.sample_period <= cfg_data;
        hpdt_pkg::CFG_SETTLE_PERIOD: cfg.settle_period <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/hpdt_tracker.sv]
// sampling, debounce and reached-event state with its single-pass update logic
`timescale 1ns / 1ps
`default_nettype none
module hpdt_tracker (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           fire,
  input  wire hpdt_pkg::item_t item,
  input  wire hpdt_pkg::cfg_t cfg,
  output hpdt_pkg::result_t   result
);

  logic [31:0] last_sample_time;
  logic [31:0] candidate_start_time;
  logic [2:0]  candidate_pos;
  logic [2:0]  stable_pos;
  logic [1:0]  reported_phase;
  logic [2:0]  reported_pos;

  logic [31:0] last_sample_time_next;
  logic [31:0] candidate_start_time_next;
  logic [2:0]  candidate_pos_next;
  logic [2:0]  stable_pos_next;
  logic [1:0]  reported_phase_next;
  logic [2:0]  reported_pos_next;

  logic [31:0] samp_diff;
  logic [31:0] deb_diff;
  logic        skip;
  logic [2:0]  hot_bits;
  logic [2:0]  raw;
  logic        deb_done;
  logic        promote;
  logic [2:0]  target;
  logic [1:0]  evt;
  logic        hit;

  assign samp_diff   = item.now_tick - last_sample_time;
  assign deb_diff    = item.now_tick - candidate_start_time;
  assign skip        = (last_sample_time != 32'd0) && (cfg.sample_period != 16'd0) &&
                       hpdt_pkg::elapsed_below(samp_diff, cfg.sample_period);
  assign hot_bits    = ~(item.hall_levels ^ {3{cfg.pin_polarity}});
  assign raw         = hpdt_pkg::decode_bits(hot_bits);
  assign deb_done    = (cfg.settle_period == 16'd0) ||
                       !hpdt_pkg::elapsed_below(deb_diff, cfg.settle_period);
  assign promote     = !skip && (candidate_pos == raw) && (stable_pos != raw) && deb_done;

  assign last_sample_time_next     = skip ? last_sample_time : item.now_tick;
  assign candidate_pos_next        = skip ? candidate_pos : raw;
  assign candidate_start_time_next = (!skip && candidate_pos != raw) ? item.now_tick
                                                                     : candidate_start_time;
  assign stable_pos_next           = promote ? raw : stable_pos;

  assign target = hpdt_pkg::phase_target(item.clean_phase);
  assign evt    = hpdt_pkg::event_of(stable_pos_next);
  assign hit    = item.is_cleaning && !item.waste_full && !item.protect &&
                  (target != hpdt_pkg::POS_UNKNOWN) && (stable_pos_next == target) &&
                  (evt != hpdt_pkg::EVT_NULL) &&
                  !((reported_phase == item.clean_phase) && (reported_pos == stable_pos_next));

  assign reported_phase_next = !item.is_cleaning ? hpdt_pkg::PH_NONE :
                               hit ? item.clean_phase : reported_phase;
  assign reported_pos_next   = hit ? stable_pos_next : reported_pos;

  assign result.held_position  = stable_pos_next;
  assign result.stable_changed = promote;
  assign result.reached_event  = hit ? evt : hpdt_pkg::EVT_NULL;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_sample_time     <= 32'd0;
      candidate_start_time <= 32'd0;
      candidate_pos        <= hpdt_pkg::POS_UNKNOWN;
      stable_pos           <= hpdt_pkg::POS_UNKNOWN;
      reported_phase       <= hpdt_pkg::PH_NONE;
      reported_pos         <= hpdt_pkg::POS_UNKNOWN;
    end else if (fire) begin
      last_sample_time     <= last_sample_time_next;
      candidate_start_time <= candidate_start_time_next;
      candidate_pos        <= candidate_pos_next;
      stable_pos           <= stable_pos_next;
      reported_phase       <= reported_phase_next;
      reported_pos         <= reported_pos_next;
    end
  end

endmodule
`default_nettype wire

[rtl/hall_position_debounce_tracker_core.sv]
// top level of the hall position debounce tracker: input stage, tracker, result stage
// a request accepted into the input register reaches the outputs through the tracker and the result register
// throughput: one request per cycle while out_ready stays high
// with a result stalled on out_ready the input stage takes one more request, then holds
// reset (rst, synchronous) empties both stages, clears the tracker state to
// unknown / never sampled, and loads pin polarity 0, sample period 10, settle period 20
`timescale 1ns / 1ps
`default_nettype none
module hall_position_debounce_tracker_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // input request channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] now_tick,
  input  wire logic [2:0]  hall_levels,
  input  wire logic        is_cleaning,
  input  wire logic [1:0]  clean_phase,
  input  wire logic        waste_full,
  input  wire logic        protect,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       held_position,
  output logic             stable_changed,
  output logic [1:0]       reached_event,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  hpdt_pkg::cfg_t    cfg;
  hpdt_pkg::item_t   item;
  hpdt_pkg::result_t result;

  logic item_valid;
  logic advance;
  logic fire;

  // the result stage can take a new value when empty or being drained
  assign advance  = !out_valid || out_ready;
  // the held request moves into the tracker and result stage together
  assign fire     = item_valid && advance;
  // input stage is free when empty or moving on this cycle
  assign in_ready = !item_valid || advance;

  hpdt_config u_config (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.now_tick    <= now_tick;
      item.hall_levels <= hall_levels;
      item.is_cleaning <= is_cleaning;
      item.clean_phase <= clean_phase;
      item.waste_full  <= waste_full;
      item.protect     <= protect;
    end
  end

  // sampling, debounce and event state, updated once per request
  hpdt_tracker u_tracker (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      held_position  <= result.held_position;
      stable_changed <= result.stable_changed;
      reached_event  <= result.reached_event;
    end
  end

endmodule
`default_nettype wire

[rtl/hpdt_checker.sv]
// port-level checks for the hall position tracker and their binding
`timescale 1ns / 1ps
`default_nettype none
module hpdt_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] held_position,
  input wire logic       stable_changed,
  input wire logic [1:0] reached_event
);

  // a stalled result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(held_position) &&
      $stable(stable_changed) && $stable(reached_event))
    else $error("result changed while stalled");

  // a reached event always names the stable position it reports
  a_event_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && (reached_event != hpdt_pkg::EVT_NULL) |->
      (reached_event == hpdt_pkg::EVT_HOME   && held_position == hpdt_pkg::POS_HOME) ||
      (reached_event == hpdt_pkg::EVT_DUMP   && held_position == hpdt_pkg::POS_DUMP) ||
      (reached_event == hpdt_pkg::EVT_RETURN && held_position == hpdt_pkg::POS_RETURN))
    else $error("reached event does not match stable position");

  // a promotion never lands on unknown
  a_changed_known: assert property (@(posedge clk) disable iff (rst)
    out_valid && stable_changed |-> held_position != hpdt_pkg::POS_UNKNOWN)
    else $error("promotion to unknown position");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

  // with the result stage empty a request is always taken
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result stage");

endmodule

bind hall_position_debounce_tracker_core hpdt_checker u_hpdt_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .held_position  (held_position),
  .stable_changed (stable_changed),
  .reached_event  (reached_event)
);
`default_nettype wire
